// ----- hdl/sfd_pkg.sv -----
// sfd_pkg: types, codes and constants shared by the SPI frame deframer files.
// No dependencies; compiled first.
`default_nettype none

package sfd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned PART_W    = 24;
	localparam int unsigned BIG_W     = 2;
	localparam int unsigned CMD_CNT_W = 5;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// command frame length, legal range 2..31
	localparam int unsigned CMD_LEN_DEF = 8;

	// result kinds
	localparam logic [KIND_W-1:0] RES_DATA   = 2'd0;
	localparam logic [KIND_W-1:0] RES_WB     = 2'd1;
	localparam logic [KIND_W-1:0] RES_CMD    = 2'd2;
	localparam logic [KIND_W-1:0] RES_HDRERR = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DATA_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WB_ID   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_ID  = 2'd2;

	// configuration reset values
	localparam logic [BYTE_W-1:0] DATA_ID_RST = 8'd1;
	localparam logic [BYTE_W-1:0] WB_ID_RST   = 8'd2;
	localparam logic [BYTE_W-1:0] CMD_ID_RST  = 8'd3;

	// byte in group that completes a word
	localparam logic [BIG_W-1:0] BIG_LAST = 2'd3;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [3:0] {
		FK_IDLE = 4'b0001,
		FK_DATA = 4'b0010,
		FK_WB   = 4'b0100,
		FK_CMD  = 4'b1000
	} frame_kind_t;

	typedef enum logic [4:0] {
		PH_HEAD1  = 5'b00001,
		PH_HEAD2  = 5'b00010,
		PH_CNT_HI = 5'b00100,
		PH_CNT_LO = 5'b01000,
		PH_DATA   = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

// ----- hdl/sfd_ifs.sv -----
// sfd_ifs: valid/ready channel interfaces of the SPI frame deframer
// (received bytes, results, configuration writes). Depends on sfd_pkg.
`default_nettype none

interface sfd_byte_if;
	import sfd_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
	import sfd_pkg::*;
	logic   valid;
	logic   ready;
	kind_t  kind;
	word_t  group_word;
	count_t group_index;
	logic   frame_end;
	count_t writeback_groups;
	count_t resend_times;
	logic   start_output;
	modport source (output valid, output kind, output group_word, output group_index,
		output frame_end, output writeback_groups, output resend_times,
		output start_output, input ready);
	modport sink   (input valid, input kind, input group_word, input group_index,
		input frame_end, input writeback_groups, input resend_times,
		input start_output, output ready);
endinterface

interface sfd_cfg_if;
	import sfd_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	byte_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/spi_frame_deframer.sv -----
// spi_frame_deframer: splits received SPI bytes into data, write-back and
// command frames. Depends on sfd_pkg and the channel interfaces in sfd_ifs.
//
// Usage:
//   rx  : one received byte per word, valid/ready.
//   res : zero or one result word per accepted byte, valid/ready. kind tells
//         data group, write-back request or command done; fields that do not
//         belong to the kind read zero.
//   cfg : register writes (index 0 data ID, 1 write-back ID, 2 command ID);
//         always ready, index 3 is ignored. Write only while idle.
// Timing: the frame state is updated in the cycle a byte is accepted and
//   any result lands in the output register, visible the next cycle. One
//   byte per cycle sustained: rx.ready is high whenever the output register
//   is empty or being drained this cycle.
// Stall: if res.ready stays low while a result is held, rx.ready drops until
//   the result is taken; nothing is lost or repeated.
// Reset: arst_n clears the frame state to idle, the counters to zero, the
//   IDs to 1/2/3, and empties the output register.
// A data frame whose count is zero swallows every later byte until reset.
`default_nettype none

module spi_frame_deframer #(
	parameter int unsigned CMD_LEN = sfd_pkg::CMD_LEN_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	sfd_byte_if.sink     rx,
	sfd_result_if.source res,
	sfd_cfg_if.sink      cfg
);
	import sfd_pkg::*;

	// command done once the byte count reaches this
	localparam logic [CMD_CNT_W-1:0] CMD_END = CMD_CNT_W'(CMD_LEN);

	// ID registers
	byte_t data_id_q, wb_id_q, cmd_id_q;

	// frame state
	frame_kind_t           kind_q, kind_nx;
	phase_t                phase_q, phase_nx;
	count_t                exp_q, exp_nx;       // expected groups
	count_t                rcv_q, rcv_nx;       // groups received (kept after frame)
	logic [BIG_W-1:0]      big_q, big_nx;       // byte in group
	logic [PART_W-1:0]     part_q, part_nx;     // first three bytes of a group
	logic [CMD_CNT_W-1:0]  ccnt_q, ccnt_nx;     // command bytes seen
	count_t                resend_q, resend_nx;

	// output register
	logic   res_valid_q;
	kind_t  res_kind_q, kind_o;
	word_t  res_word_q, word_o;
	count_t res_index_q, index_o;
	logic   res_end_q, end_o;
	count_t res_wbg_q, wbg_o;
	count_t res_resend_q, resend_o;
	logic   res_start_q, start_o;
	logic   emit;

	logic                 rx_acc;
	byte_t                b;
	logic [CMD_CNT_W-1:0] ccnt_inc;
	count_t               rcv_inc;

	assign rx.ready  = !res_valid_q || res.ready;
	assign rx_acc    = rx.valid && rx.ready;
	assign b         = rx.rx_byte;
	assign cfg.ready = 1'b1;
	assign ccnt_inc  = ccnt_q + CMD_CNT_W'(1);
	assign rcv_inc   = rcv_q + COUNT_W'(1);

	// per-byte frame step
	always_comb begin
		kind_nx   = kind_q;
		phase_nx  = phase_q;
		exp_nx    = exp_q;
		rcv_nx    = rcv_q;
		big_nx    = big_q;
		part_nx   = part_q;
		ccnt_nx   = ccnt_q;
		resend_nx = resend_q;
		emit      = 1'b0;
		kind_o    = RES_DATA;
		word_o    = '0;
		index_o   = '0;
		end_o     = 1'b0;
		wbg_o     = '0;
		resend_o  = '0;
		start_o   = 1'b0;
		case (kind_q)
			FK_IDLE: begin
				// priority: data, then write-back, then command
				if (b == data_id_q) begin
					exp_nx   = '0;
					rcv_nx   = '0;
					big_nx   = '0;
					part_nx  = '0;
					kind_nx  = FK_DATA;
					phase_nx = PH_HEAD1;
				end else if (b == wb_id_q) begin
					kind_nx  = FK_WB;
					phase_nx = PH_HEAD1;
				end else if (b == cmd_id_q) begin
					ccnt_nx   = '0;
					resend_nx = '0;
					kind_nx   = FK_CMD;
				end
			end
			FK_DATA, FK_WB: begin
				case (phase_q)
					PH_HEAD1, PH_HEAD2: begin
						if (b == '0) begin
							phase_nx = (phase_q == PH_HEAD1) ? PH_HEAD2 : PH_CNT_HI;
						end else begin
							// bad header byte: back to idle, data frame drops its groups
							if (kind_q == FK_DATA) begin
								exp_nx  = '0;
								rcv_nx  = '0;
								big_nx  = '0;
								part_nx = '0;
							end
							kind_nx  = FK_IDLE;
							phase_nx = PH_HEAD1;
						end
					end
					PH_CNT_HI: begin
						phase_nx = PH_CNT_LO;
						if (kind_q == FK_DATA) begin
							exp_nx = {b, BYTE_W'(0)};
						end else begin
							emit    = 1'b1;
							kind_o  = RES_WB;
							wbg_o   = rcv_q;
						end
					end
					PH_CNT_LO: begin
						if (kind_q == FK_DATA) begin
							exp_nx   = {exp_q[COUNT_W-1:BYTE_W], b};
							phase_nx = PH_DATA;
						end else begin
							kind_nx  = FK_IDLE;
							phase_nx = PH_HEAD1;
						end
					end
					PH_DATA: begin
						if (kind_q == FK_DATA) begin
							// zero count never passes this test: frame hangs until reset
							if (rcv_q < exp_q) begin
								if (big_q != BIG_LAST) begin
									part_nx = {part_q[PART_W-BYTE_W-1:0], b};
									big_nx  = big_q + BIG_W'(1);
								end else begin
									emit    = 1'b1;
									kind_o  = RES_DATA;
									word_o  = {part_q, b};
									index_o = rcv_q;
									rcv_nx  = rcv_inc;
									big_nx  = '0;
									part_nx = '0;
									if (rcv_inc == exp_q) begin
										end_o    = 1'b1;
										kind_nx  = FK_IDLE;
										phase_nx = PH_HEAD1;
									end
								end
							end
						end else begin
							kind_nx  = FK_IDLE;
							phase_nx = PH_HEAD1;
						end
					end
					default: begin
						kind_nx  = FK_IDLE;
						phase_nx = PH_HEAD1;
					end
				endcase
			end
			FK_CMD: begin
				if (ccnt_q == CMD_CNT_W'(0)) begin
					resend_nx = {b, resend_q[BYTE_W-1:0]};
				end else if (ccnt_q == CMD_CNT_W'(1)) begin
					resend_nx = {resend_q[COUNT_W-1:BYTE_W], b};
				end
				ccnt_nx = ccnt_inc;
				if (ccnt_inc >= CMD_END) begin
					kind_nx  = FK_IDLE;
					emit     = 1'b1;
					kind_o   = RES_CMD;
					resend_o = resend_nx;
					start_o  = (rcv_q != '0);
				end
			end
			default: begin
				kind_nx  = FK_IDLE;
				phase_nx = PH_HEAD1;
			end
		endcase
	end

	// ID registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_id_q <= DATA_ID_RST;
			wb_id_q   <= WB_ID_RST;
			cmd_id_q  <= CMD_ID_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DATA_ID: data_id_q <= cfg.data;
				REG_WB_ID:   wb_id_q   <= cfg.data;
				REG_CMD_ID:  cmd_id_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= FK_IDLE;
			phase_q  <= PH_HEAD1;
			exp_q    <= '0;
			rcv_q    <= '0;
			big_q    <= '0;
			part_q   <= '0;
			ccnt_q   <= '0;
			resend_q <= '0;
		end else if (rx_acc) begin
			kind_q   <= kind_nx;
			phase_q  <= phase_nx;
			exp_q    <= exp_nx;
			rcv_q    <= rcv_nx;
			big_q    <= big_nx;
			part_q   <= part_nx;
			ccnt_q   <= ccnt_nx;
			resend_q <= resend_nx;
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_acc && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (rx_acc && emit) begin
			res_kind_q   <= kind_o;
			res_word_q   <= word_o;
			res_index_q  <= index_o;
			res_end_q    <= end_o;
			res_wbg_q    <= wbg_o;
			res_resend_q <= resend_o;
			res_start_q  <= start_o;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.kind             = res_kind_q;
	assign res.group_word       = res_word_q;
	assign res.group_index      = res_index_q;
	assign res.frame_end        = res_end_q;
	assign res.writeback_groups = res_wbg_q;
	assign res.resend_times     = res_resend_q;
	assign res.start_output     = res_start_q;

endmodule

`default_nettype wire
